// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms used by the checker in tsk_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tsk_pkg.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stage kinematics package
// Shared constants, register codes and pipeline sideband type.
// ----------------------------------------------------------------------------
package tsk_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // reset geometry in millimetres; upper in half millimetres, tip in thousandths
    localparam int LINK_MM       = 124;
    localparam int TOPW_MM       = 84;
    localparam int LOWER_MM      = 12;
    localparam int UPPER_HALF_MM = 135;
    localparam int TIP_MILLI     = 259075;
    localparam int MILLI         = 1000;

    localparam int ROOT_BITS  = 31;
    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int ROOT_LANES = 2;
    localparam int EXT_BITS   = 36;

    typedef enum logic [2:0] {
        CFG_LINK  = 3'd0,
        CFG_TOPW  = 3'd1,
        CFG_LOWER = 3'd2,
        CFG_UPPER = 3'd3,
        CFG_TIP   = 3'd4,
        CFG_PDO   = 3'd5,
        CFG_NHO   = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_INV = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               bad0;
        logic               bad1;
        logic signed [31:0] tip_x;
        logic signed [31:0] rear_x;
        logic signed [33:0] tip_z;
        logic signed [31:0] x;
        logic signed [32:0] zin;
    } t_side;

endpackage

// ===== src/trapezoid_stage_kinematics.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stage kinematics
// Forward and inverse kinematics of a two-trapezoid needle stage, Q16.16 mm.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  cfg       in         i_cfg_we            i_cfg_idx, i_cfg_data
//  request   in         i_valid / o_stall   i_opcode, sliders, depth, target
//  result    out        o_valid / i_stall   tip, rear pivot, sliders, flag
//
//  One item per cycle unless a held result stalls the input; items pass
//  five front stages, 31 root stages (one root bit each) and two back stages.
//  Reset clears all valid bits and loads the default geometry.
//  A held result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module trapezoid_stage_kinematics
    import tsk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_front_slider_a,
    input  logic signed [31:0] i_front_slider_b,
    input  logic signed [31:0] i_rear_slider_a,
    input  logic signed [31:0] i_rear_slider_b,
    input  logic signed [31:0] i_insertion_depth,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_tip_x,
    output logic signed [31:0] o_tip_y,
    output logic signed [31:0] o_tip_z,
    output logic signed [31:0] o_rear_pivot_x,
    output logic signed [31:0] o_rear_pivot_y,
    output logic signed [31:0] o_front_slider_a_out,
    output logic signed [31:0] o_front_slider_b_out,
    output logic signed [31:0] o_rear_slider_a_out,
    output logic signed [31:0] o_rear_slider_b_out,
    output logic signed [31:0] o_insertion_out,
    output logic               o_unreachable
);

    localparam int XW = (WORD_BITS > EXT_BITS) ? WORD_BITS : EXT_BITS;

    localparam logic [63:0] LINK_RST  = 64'(LINK_MM) << FRAC_BITS;
    localparam logic [63:0] TOPW_RST  = 64'(TOPW_MM) << FRAC_BITS;
    localparam logic [63:0] LOWER_RST = 64'(LOWER_MM) << FRAC_BITS;
    localparam logic [63:0] UPPER_RST = 64'(UPPER_HALF_MM) << (FRAC_BITS - 1);
    localparam logic [63:0] TIP_RST   =
        ((64'(TIP_MILLI) << FRAC_BITS) + 64'(MILLI / 2)) / 64'(MILLI);

    function automatic logic [31:0] sat32(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[31:0];
        end else if (v < lo) begin
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    // configuration
    logic [30:0]        r_link;
    logic [30:0]        r_topw;
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic signed [31:0] r_tip;
    logic signed [31:0] r_pdo;
    logic signed [31:0] r_nho;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link  <= LINK_RST[30:0];
            r_topw  <= TOPW_RST[30:0];
            r_lower <= LOWER_RST[31:0];
            r_upper <= UPPER_RST[31:0];
            r_tip   <= TIP_RST[31:0];
            r_pdo   <= '0;
            r_nho   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LINK:  r_link  <= i_cfg_data[30:0];
                CFG_TOPW:  r_topw  <= i_cfg_data[30:0];
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_TIP:   r_tip   <= i_cfg_data;
                CFG_PDO:   r_pdo   <= i_cfg_data;
                CFG_NHO:   r_nho   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic               en;
    logic               r_out_valid;
    logic signed [32:0] base;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign base    = 33'(r_lower) + 33'(r_upper);

    // stage 1: input register
    logic               r_p1_valid;
    t_op                r_p1_op;
    logic signed [31:0] r_p1_fa, r_p1_fb, r_p1_ra, r_p1_rb, r_p1_ins;
    logic signed [31:0] r_p1_x, r_p1_y, r_p1_z;

    // stage 2: differences and sums
    logic               r_p2_valid;
    logic signed [33:0] r_p2_d0, r_p2_d1;
    t_side              r_p2_side;
    logic signed [33:0] d_f, d_r, d_e;
    logic signed [32:0] sum_f, sum_r;
    t_side              p2_side;

    always_comb begin
        d_f   = 34'(r_p1_fa) - 34'(r_p1_fb) - 34'(r_topw);
        d_r   = 34'(r_p1_ra) - 34'(r_p1_rb) - 34'(r_topw);
        d_e   = 34'(r_p1_y) - 34'(base);
        sum_f = 33'(r_p1_fa) + 33'(r_p1_fb);
        sum_r = 33'(r_p1_ra) + 33'(r_p1_rb);
        p2_side.op     = r_p1_op;
        p2_side.bad0   = 1'b0;
        p2_side.bad1   = 1'b0;
        p2_side.tip_x  = sum_f[32:1];
        p2_side.rear_x = sum_r[32:1];
        p2_side.tip_z  = 34'(r_tip) + 34'(r_p1_ins) - 34'(r_pdo);
        p2_side.x      = r_p1_x;
        p2_side.zin    = 33'(r_p1_z) - 33'(r_tip);
    end

    // stage 3: magnitude, reach check, half gap
    logic               r_p3_valid;
    logic [30:0]        r_p3_h0, r_p3_h1;
    logic               r_p3_b0, r_p3_b1;
    t_side              r_p3_side;
    logic [33:0]        ad0, ad1, lim0;
    logic               inv3;
    t_side              p3_side;

    always_comb begin
        inv3 = (r_p2_side.op == OP_INV);
        ad0  = r_p2_d0[33] ? 34'(-r_p2_d0) : r_p2_d0;
        ad1  = r_p2_d1[33] ? 34'(-r_p2_d1) : r_p2_d1;
        lim0 = inv3 ? {3'b000, r_link} : {2'b00, r_link, 1'b0};
        p3_side      = r_p2_side;
        p3_side.bad0 = ad0 > lim0;
        p3_side.bad1 = !inv3 && (ad1 > {2'b00, r_link, 1'b0});
    end

    // stage 4: squares
    logic               r_p4_valid;
    logic [RAD_BITS-1:0] r_p4_sq_l, r_p4_sq0, r_p4_sq1;
    logic [31:0]        r_p4_hb0, r_p4_hb1;
    t_side              r_p4_side;

    // stage 5: radicands
    logic               r_p5_valid;
    logic [ROOT_LANES-1:0][RAD_BITS-1:0] r_p5_rad;
    t_side              r_p5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_p5_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_p5_valid <= r_p4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_op  <= t_op'(i_opcode);
            r_p1_fa  <= i_front_slider_a;
            r_p1_fb  <= i_front_slider_b;
            r_p1_ra  <= i_rear_slider_a;
            r_p1_rb  <= i_rear_slider_b;
            r_p1_ins <= i_insertion_depth;
            r_p1_x   <= i_target_x;
            r_p1_y   <= i_target_y;
            r_p1_z   <= i_target_z;

            r_p2_d0   <= (r_p1_op == OP_INV) ? d_e : d_f;
            r_p2_d1   <= d_r;
            r_p2_side <= p2_side;

            r_p3_h0   <= inv3 ? ad0[30:0] : ad0[31:1];
            r_p3_b0   <= !inv3 && ad0[0];
            r_p3_h1   <= ad1[31:1];
            r_p3_b1   <= ad1[0];
            r_p3_side <= p3_side;

            r_p4_sq_l <= RAD_BITS'(r_link) * RAD_BITS'(r_link);
            r_p4_sq0  <= RAD_BITS'(r_p3_h0) * RAD_BITS'(r_p3_h0);
            r_p4_sq1  <= RAD_BITS'(r_p3_h1) * RAD_BITS'(r_p3_h1);
            r_p4_hb0  <= r_p3_b0 ? 32'(r_p3_h0) + 32'd1 : 32'd0;
            r_p4_hb1  <= r_p3_b1 ? 32'(r_p3_h1) + 32'd1 : 32'd0;
            r_p4_side <= r_p3_side;

            r_p5_rad[0] <= r_p4_side.bad0 ? '0 :
                           r_p4_sq_l - r_p4_sq0 - RAD_BITS'(r_p4_hb0);
            r_p5_rad[1] <= (r_p4_side.bad1 || r_p4_side.op == OP_INV) ? '0 :
                           r_p4_sq_l - r_p4_sq1 - RAD_BITS'(r_p4_hb1);
            r_p5_side   <= r_p4_side;
        end
    end

    // root pipeline
    logic                                  sq_valid;
    logic [ROOT_LANES-1:0][ROOT_BITS-1:0]  sq_root;
    t_side                                 sq_side;

    tsk_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p5_valid),
        .i_rad   (r_p5_rad),
        .i_side  (r_p5_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 6: add roots back in
    logic               r_p6_valid;
    logic signed [34:0] r_p6_tip_y;
    logic signed [33:0] r_p6_rear_y;
    logic signed [33:0] r_p6_s1;
    t_side              r_p6_side;

    // stage 7: output register
    logic signed [34:0] s2;
    logic [31:0]        r_out_tip_x, r_out_tip_y, r_out_tip_z;
    logic [31:0]        r_out_rear_x, r_out_rear_y;
    logic [31:0]        r_out_s1, r_out_s2, r_out_ins;
    logic               r_out_bad;
    logic               inv7;

    always_comb begin
        inv7 = (r_p6_side.op == OP_INV);
        s2   = (35'(r_p6_side.x) <<< 1) - 35'(r_p6_s1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p6_valid  <= sq_valid;
            r_out_valid <= r_p6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p6_tip_y  <= 35'(r_nho) + 35'(base) + 35'(sq_root[0]);
            r_p6_rear_y <= 34'(base) + 34'(sq_root[1]);
            r_p6_s1     <= 34'(sq_side.x) + 34'(sq_root[0]) + 34'(r_topw[30:1]);
            r_p6_side   <= sq_side;

            r_out_tip_x  <= inv7 ? '0 : sat32(XW'(r_p6_side.tip_x));
            r_out_tip_y  <= inv7 ? '0 : sat32(XW'(r_p6_tip_y));
            r_out_tip_z  <= inv7 ? '0 : sat32(XW'(r_p6_side.tip_z));
            r_out_rear_x <= inv7 ? '0 : sat32(XW'(r_p6_side.rear_x));
            r_out_rear_y <= inv7 ? '0 : sat32(XW'(r_p6_rear_y));
            r_out_s1     <= inv7 ? sat32(XW'(r_p6_s1)) : '0;
            r_out_s2     <= inv7 ? sat32(XW'(s2)) : '0;
            r_out_ins    <= inv7 ? sat32(XW'(r_p6_side.zin)) : '0;
            r_out_bad    <= r_p6_side.bad0 || r_p6_side.bad1;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_tip_x              = r_out_tip_x;
    assign o_tip_y              = r_out_tip_y;
    assign o_tip_z              = r_out_tip_z;
    assign o_rear_pivot_x       = r_out_rear_x;
    assign o_rear_pivot_y       = r_out_rear_y;
    assign o_front_slider_a_out = r_out_s1;
    assign o_front_slider_b_out = r_out_s2;
    assign o_rear_slider_a_out  = r_out_s1;
    assign o_rear_slider_b_out  = r_out_s2;
    assign o_insertion_out      = r_out_ins;
    assign o_unreachable        = r_out_bad;

endmodule

// ===== src/tsk_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Two lanes, one root bit resolved per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module tsk_sqrt
    import tsk_pkg::*;
(
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [ROOT_LANES-1:0][RAD_BITS-1:0]   i_rad,
    input  t_side                                 i_side,
    output logic                                  o_valid,
    output logic [ROOT_LANES-1:0][ROOT_BITS-1:0]  o_root,
    output t_side                                 o_side
);

    logic [ROOT_BITS-1:0] r_valid;
    logic [RAD_BITS-1:0]  r_rem   [ROOT_LANES][ROOT_BITS];
    logic [ROOT_BITS-1:0] r_q     [ROOT_LANES][ROOT_BITS];
    t_side                r_side  [ROOT_BITS];

    logic [RAD_BITS-1:0]  src_rem [ROOT_LANES][ROOT_BITS];
    logic [ROOT_BITS-1:0] src_q   [ROOT_LANES][ROOT_BITS];
    logic [RAD_BITS-1:0]  n_rem   [ROOT_LANES][ROOT_BITS];
    logic [ROOT_BITS-1:0] n_q     [ROOT_LANES][ROOT_BITS];

    always_comb begin
        for (int l = 0; l < ROOT_LANES; l++) begin
            src_rem[l][0] = i_rad[l];
            src_q[l][0]   = '0;
            for (int k = 1; k < ROOT_BITS; k++) begin
                src_rem[l][k] = r_rem[l][k-1];
                src_q[l][k]   = r_q[l][k-1];
            end
        end
    end

    always_comb begin
        logic [RAD_BITS+1:0] trial;
        logic                take;
        for (int l = 0; l < ROOT_LANES; l++) begin
            for (int k = 0; k < ROOT_BITS; k++) begin
                trial = (RAD_BITS+2)'({src_q[l][k], 2'b01}) << (2 * (ROOT_BITS - 1 - k));
                take  = {2'b00, src_rem[l][k]} >= trial;
                n_rem[l][k] = take ? src_rem[l][k] - trial[RAD_BITS-1:0] : src_rem[l][k];
                n_q[l][k]   = {src_q[l][k][ROOT_BITS-2:0], take};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[ROOT_BITS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < ROOT_BITS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int l = 0; l < ROOT_LANES; l++) begin
                for (int k = 0; k < ROOT_BITS; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_q[l][k]   <= n_q[l][k];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < ROOT_LANES; l++) begin
            o_root[l] = r_q[l][ROOT_BITS-1];
        end
    end

    assign o_valid = r_valid[ROOT_BITS-1];
    assign o_side  = r_side[ROOT_BITS-1];

endmodule

// ===== src/tsk_checker.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stage kinematics checker
// Port-level checks on stall, result hold, slider pair symmetry and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_stall,
    input logic               o_valid,
    input logic signed [31:0] o_tip_x,
    input logic signed [31:0] o_tip_y,
    input logic signed [31:0] o_tip_z,
    input logic signed [31:0] o_rear_pivot_x,
    input logic signed [31:0] o_rear_pivot_y,
    input logic signed [31:0] o_front_slider_a_out,
    input logic signed [31:0] o_front_slider_b_out,
    input logic signed [31:0] o_rear_slider_a_out,
    input logic signed [31:0] o_rear_slider_b_out,
    input logic signed [31:0] o_insertion_out,
    input logic               o_unreachable
);

    `ASSERT_CLK(a_stall_only_when_held, i_clk, i_rst_n,
        o_stall == (o_valid && i_stall), "input stalled without a held result")

    `ASSERT_CLK(a_held_result_stable, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable({o_tip_x, o_tip_y, o_tip_z,
            o_rear_pivot_x, o_rear_pivot_y, o_front_slider_a_out,
            o_front_slider_b_out, o_insertion_out, o_unreachable})),
        "held result changed")

    `ASSERT_CLK(a_slider_pairs_match, i_clk, i_rst_n,
        o_valid |-> (o_front_slider_a_out == o_rear_slider_a_out &&
                     o_front_slider_b_out == o_rear_slider_b_out),
        "front and rear slider results differ")

    `ASSERT_ALWAYS(a_no_result_after_reset, i_clk,
        !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

bind trapezoid_stage_kinematics tsk_checker u_tsk_checker (.*);

// ===== tb/sv/stage_kinematics_checker.sv =====
// ----------------------------------------------------------------------------
// Stage kinematics checker
// Watches the request, result and register ports of the trapezoid stage.
// Computes expected tip, pivot, slider and insertion words for every request
// transfer from its own copy of the geometry registers. Compares each result
// transfer field by field, in order, with the oldest pending pose.
// ----------------------------------------------------------------------------
module stage_kinematics_checker
    import tsk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_front_slider_a,
    input  logic signed [31:0] i_front_slider_b,
    input  logic signed [31:0] i_rear_slider_a,
    input  logic signed [31:0] i_rear_slider_b,
    input  logic signed [31:0] i_insertion_depth,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic signed [31:0] i_tip_x,
    input  logic signed [31:0] i_tip_y,
    input  logic signed [31:0] i_tip_z,
    input  logic signed [31:0] i_rear_pivot_x,
    input  logic signed [31:0] i_rear_pivot_y,
    input  logic signed [31:0] i_front_slider_a_out,
    input  logic signed [31:0] i_front_slider_b_out,
    input  logic signed [31:0] i_rear_slider_a_out,
    input  logic signed [31:0] i_rear_slider_b_out,
    input  logic signed [31:0] i_insertion_out,
    input  logic               i_unreachable,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic             unreachable;
        logic [9:0][31:0] word;
    } t_pose;

    string field_name [10] = '{
        "tip_x", "tip_y", "tip_z", "rear_pivot_x", "rear_pivot_y",
        "front_slider_a_out", "front_slider_b_out",
        "rear_slider_a_out", "rear_slider_b_out", "insertion_out"
    };

    longint link_len;
    longint top_w;
    longint lower_ofs;
    longint upper_ofs;
    longint tip_ofs;
    longint pivot_ofs;
    longint needle_ofs;

    t_pose pose_queue [$];
    int    misses = 0;

    assign o_fail_count = misses;

    function automatic logic [31:0] clamp_word(input longint v);
        if (v > WORD_MAX) return 32'h7FFF_FFFF;
        if (v < WORD_MIN) return 32'h8000_0000;
        return 32'(v);
    endfunction

    function automatic longint halve(input longint v);
        return v >>> 1;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned cand;
        res = 0;
        for (int i = 31; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    // root of L^2 - (d/2)^2, scaled by four to stay exact
    function automatic longint gap_root(input longint d, inout logic bad);
        longint unsigned mag;
        longint unsigned two_l;
        mag = (d < 0) ? -d : d;
        two_l = 2 * link_len;
        if (mag > two_l) begin
            bad = 1'b1;
            return 0;
        end
        return longint'(floor_root((two_l * two_l - mag * mag) >> 2));
    endfunction

    function automatic longint height_root(input longint e, inout logic bad);
        longint unsigned mag;
        longint unsigned lu;
        mag = (e < 0) ? -e : e;
        lu = link_len;
        if (mag > lu) begin
            bad = 1'b1;
            return 0;
        end
        return longint'(floor_root(lu * lu - mag * mag));
    endfunction

    function automatic t_pose predict_pose(input t_op op, input longint fa, fb, ra, rb,
                                           dep, x, y, z);
        t_pose  p;
        logic   bad;
        longint base;
        longint r;
        longint s1;
        longint s2;
        p = '0;
        bad = 1'b0;
        base = lower_ofs + upper_ofs;
        if (op == OP_FWD) begin
            p.word[0] = clamp_word(halve(fa + fb));
            p.word[1] = clamp_word(needle_ofs + base + gap_root(fa - fb - top_w, bad));
            p.word[2] = clamp_word(tip_ofs + dep - pivot_ofs);
            p.word[3] = clamp_word(halve(ra + rb));
            p.word[4] = clamp_word(base + gap_root(ra - rb - top_w, bad));
        end else begin
            r = height_root(y - base, bad);
            s1 = halve(2 * x + top_w + 2 * r);
            s2 = 2 * x - s1;
            p.word[5] = clamp_word(s1);
            p.word[6] = clamp_word(s2);
            p.word[7] = clamp_word(s1);
            p.word[8] = clamp_word(s2);
            p.word[9] = clamp_word(z - tip_ofs);
        end
        p.unreachable = bad;
        return p;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (misses < REPORT_LIMIT)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, seen);
        misses++;
    endtask

    always @(posedge i_clk) begin
        t_pose got;
        t_pose want;
        if (!i_rst_n) begin
            link_len   = longint'(LINK_MM) << FRAC_BITS_DEF;
            top_w      = longint'(TOPW_MM) << FRAC_BITS_DEF;
            lower_ofs  = longint'(LOWER_MM) << FRAC_BITS_DEF;
            upper_ofs  = longint'(UPPER_HALF_MM) << (FRAC_BITS_DEF - 1);
            tip_ofs    = ((longint'(TIP_MILLI) << FRAC_BITS_DEF) + MILLI / 2) / MILLI;
            pivot_ofs  = 0;
            needle_ofs = 0;
            pose_queue.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = {i_unreachable, i_insertion_out, i_rear_slider_b_out,
                       i_rear_slider_a_out, i_front_slider_b_out, i_front_slider_a_out,
                       i_rear_pivot_y, i_rear_pivot_x, i_tip_z, i_tip_y, i_tip_x};
                if (pose_queue.size() == 0) begin
                    note_mismatch("result with nothing pending", '0, got.word[0]);
                end else begin
                    want = pose_queue.pop_front();
                    for (int k = 0; k < 10; k++)
                        if (got.word[k] !== want.word[k])
                            note_mismatch(field_name[k], want.word[k], got.word[k]);
                    if (got.unreachable !== want.unreachable)
                        note_mismatch("unreachable", 32'(want.unreachable),
                                      32'(got.unreachable));
                end
            end
            if (i_req_valid && !i_req_stall)
                pose_queue.push_back(predict_pose(t_op'(i_opcode),
                    longint'(i_front_slider_a), longint'(i_front_slider_b),
                    longint'(i_rear_slider_a), longint'(i_rear_slider_b),
                    longint'(i_insertion_depth), longint'(i_target_x),
                    longint'(i_target_y), longint'(i_target_z)));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LINK:  link_len   = longint'(i_cfg_data[30:0]);
                    CFG_TOPW:  top_w      = longint'(i_cfg_data[30:0]);
                    CFG_LOWER: lower_ofs  = longint'($signed(i_cfg_data));
                    CFG_UPPER: upper_ofs  = longint'($signed(i_cfg_data));
                    CFG_TIP:   tip_ofs    = longint'($signed(i_cfg_data));
                    CFG_PDO:   pivot_ofs  = longint'($signed(i_cfg_data));
                    CFG_NHO:   needle_ofs = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
        end
        o_pending <= pose_queue.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Trapezoid stage kinematics testbench
// Drives forward and inverse requests through the stage under several
// geometry settings, from the reset geometry to the register extremes.
// A directed set covers root edges, flagged poses and saturation. Random
// requests follow, mostly reachable poses, some on or just past the boundary,
// with random idle bursts on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import tsk_pkg::*;

    localparam int N_REGS   = CFG_NHO + 1;
    localparam int LATENCY  = 38;
    localparam int N_PHASES = 8;
    localparam int N_RANDOM = 240;

    localparam logic [31:0] RESET_GEOM [N_REGS] = '{
        32'(LINK_MM) << FRAC_BITS_DEF,
        32'(TOPW_MM) << FRAC_BITS_DEF,
        32'(LOWER_MM) << FRAC_BITS_DEF,
        32'(UPPER_HALF_MM) << (FRAC_BITS_DEF - 1),
        32'(((longint'(TIP_MILLI) << FRAC_BITS_DEF) + MILLI / 2) / MILLI),
        32'd0,
        32'd0
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_opcode = 1'b0;
    logic signed [31:0] i_front_slider_a = '0;
    logic signed [31:0] i_front_slider_b = '0;
    logic signed [31:0] i_rear_slider_a = '0;
    logic signed [31:0] i_rear_slider_b = '0;
    logic signed [31:0] i_insertion_depth = '0;
    logic signed [31:0] i_target_x = '0;
    logic signed [31:0] i_target_y = '0;
    logic signed [31:0] i_target_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_tip_x;
    logic signed [31:0] o_tip_y;
    logic signed [31:0] o_tip_z;
    logic signed [31:0] o_rear_pivot_x;
    logic signed [31:0] o_rear_pivot_y;
    logic signed [31:0] o_front_slider_a_out;
    logic signed [31:0] o_front_slider_b_out;
    logic signed [31:0] o_rear_slider_a_out;
    logic signed [31:0] o_rear_slider_b_out;
    logic signed [31:0] o_insertion_out;
    logic               o_unreachable;

    int          fail_count;
    int          pending;
    bit          calm = 1'b0;
    bit          rx_long_hold = 1'b0;
    longint      geom [N_REGS];
    logic [31:0] geom_set [N_REGS];

    trapezoid_stage_kinematics dut (.*);

    stage_kinematics_checker checker_i (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_req_valid          (i_valid),
        .i_req_stall          (o_stall),
        .i_opcode             (i_opcode),
        .i_front_slider_a     (i_front_slider_a),
        .i_front_slider_b     (i_front_slider_b),
        .i_rear_slider_a      (i_rear_slider_a),
        .i_rear_slider_b      (i_rear_slider_b),
        .i_insertion_depth    (i_insertion_depth),
        .i_target_x           (i_target_x),
        .i_target_y           (i_target_y),
        .i_target_z           (i_target_z),
        .i_res_valid          (o_valid),
        .i_res_stall          (i_stall),
        .i_tip_x              (o_tip_x),
        .i_tip_y              (o_tip_y),
        .i_tip_z              (o_tip_z),
        .i_rear_pivot_x       (o_rear_pivot_x),
        .i_rear_pivot_y       (o_rear_pivot_y),
        .i_front_slider_a_out (o_front_slider_a_out),
        .i_front_slider_b_out (o_front_slider_b_out),
        .i_rear_slider_a_out  (o_rear_slider_a_out),
        .i_rear_slider_b_out  (o_rear_slider_b_out),
        .i_insertion_out      (o_insertion_out),
        .i_unreachable        (o_unreachable),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint spread(input longint span);
        longint unsigned r;
        if (span <= 0) return 0;
        r = {$urandom(), $urandom()};
        return longint'(r % (2 * span + 1)) - span;
    endfunction

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 3)) - 32'd1;
            3: return 32'(spread(longint'(1) << 24));
            default: return $urandom();
        endcase
    endfunction

    function automatic longint either_sign(input longint v);
        return ($urandom_range(0, 1) != 0) ? v : -v;
    endfunction

    // slider with gap to b inside, on or just past the link reach, or random
    function automatic logic [31:0] gap_partner(input logic [31:0] b);
        longint two_l;
        longint d;
        two_l = 2 * geom[CFG_LINK];
        case ($urandom_range(0, 9))
            6, 7: d = either_sign(two_l + longint'($urandom_range(0, 2)));
            8, 9: return $urandom();
            default: d = spread(two_l);
        endcase
        return 32'(longint'($signed(b)) + geom[CFG_TOPW] + d);
    endfunction

    function automatic logic [31:0] moderate_word();
        if ($urandom_range(0, 3) == 0) return any_word();
        return 32'(spread(longint'(1) << 28));
    endfunction

    task automatic offer(input t_op op, input logic [31:0] fa, fb, ra, rb, dep, x, y, z);
        i_opcode          <= op;
        i_front_slider_a  <= fa;
        i_front_slider_b  <= fb;
        i_rear_slider_a   <= ra;
        i_rear_slider_b   <= rb;
        i_insertion_depth <= dep;
        i_target_x        <= x;
        i_target_y        <= y;
        i_target_z        <= z;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (!calm && $urandom_range(0, 11) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_fwd(input logic [31:0] fa, fb, ra, rb, dep);
        offer(OP_FWD, fa, fb, ra, rb, dep, $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_inv(input logic [31:0] x, y, z);
        offer(OP_INV, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), x, y, z);
    endtask

    task automatic rand_forward();
        logic [31:0] fb;
        logic [31:0] rb;
        fb = moderate_word();
        rb = moderate_word();
        send_fwd(gap_partner(fb), fb, gap_partner(rb), rb, any_word());
    endtask

    task automatic rand_inverse();
        longint base;
        longint l;
        longint y;
        base = geom[CFG_LOWER] + geom[CFG_UPPER];
        l = geom[CFG_LINK];
        case ($urandom_range(0, 9))
            6, 7: y = base + either_sign(l + longint'($urandom_range(0, 1)));
            8, 9: y = longint'($urandom());
            default: y = base + spread(l);
        endcase
        send_inv(moderate_word(), 32'(y), any_word());
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_geometry();
        for (int k = CFG_LINK; k <= CFG_NHO; k++) begin
            i_cfg_idx  <= k[2:0];
            i_cfg_data <= geom_set[k];
            i_cfg_we   <= 1'b1;
            @(posedge i_clk);
            if (k <= CFG_TOPW)
                geom[k] = longint'(geom_set[k][30:0]);
            else
                geom[k] = longint'($signed(geom_set[k]));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        longint l;
        longint tw;
        longint base;
        for (int k = 0; k < N_REGS; k++)
            geom[k] = longint'($signed(RESET_GEOM[k]));
        l = geom[CFG_LINK];
        tw = geom[CFG_TOPW];
        base = geom[CFG_LOWER] + geom[CFG_UPPER];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_fwd('0, '0, '0, '0, '0);
        send_fwd(32'(100 << 16), 32'(16 << 16), 32'(16 << 16), 32'(100 << 16), 32'(50 << 16));
        send_fwd(32'(tw + 2 * l), '0, '0, 32'(2 * l - tw), 32'd1);
        send_fwd(32'(tw + 2 * l + 1), '0, '0, '0, 32'd2);
        send_fwd('0, '0, '0, 32'(2 * l - tw + 1), 32'd3);
        send_fwd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_fwd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_fwd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fwd(-32'sd3, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fwd(32'(7 << 16), 32'(3 << 16), 32'd5, -32'sd4, 32'h8000_0000);
        send_inv('0, '0, '0);
        send_inv('0, 32'(base), '0);
        send_inv(32'(5 << 16), 32'(base + l), 32'(1 << 16));
        send_inv(-32'sd327680, 32'(base + l + 1), '0);
        send_inv('0, 32'(base - l - 1), '0);
        send_inv('0, 32'(base - l), '0);
        send_inv(32'h7FFF_FFFF, 32'(base), 32'h7FFF_FFFF);
        send_inv(32'h8000_0000, 32'(base), 32'h8000_0000);
        send_inv(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_inv(32'd3, 32'(base + l / 2), 32'd12345);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: geom_set = '{RESET_GEOM[CFG_LINK], RESET_GEOM[CFG_TOPW],
                                RESET_GEOM[CFG_LOWER], RESET_GEOM[CFG_UPPER],
                                RESET_GEOM[CFG_TIP], 32'(10 << 16), 32'(-(3 << 16))};
                1: geom_set = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
                2: geom_set = '{32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
                3, 5: begin
                    for (int k = 0; k < N_REGS; k++) geom_set[k] = $urandom();
                end
                6: begin
                    geom_set = RESET_GEOM;
                    geom_set[CFG_LINK] = RESET_GEOM[CFG_LINK] | 32'h8000_0000;
                    geom_set[CFG_TOPW] = RESET_GEOM[CFG_TOPW] | 32'h8000_0000;
                end
                default: begin
                    geom_set[CFG_LINK]  = $urandom_range(1 << 16, 200 << 16);
                    geom_set[CFG_TOPW]  = $urandom_range(0, 150 << 16);
                    geom_set[CFG_LOWER] = 32'(spread(longint'(100) << 16));
                    geom_set[CFG_UPPER] = 32'(spread(longint'(100) << 16));
                    geom_set[CFG_TIP]   = 32'(spread(longint'(300) << 16));
                    geom_set[CFG_PDO]   = 32'(spread(longint'(50) << 16));
                    geom_set[CFG_NHO]   = 32'(spread(longint'(50) << 16));
                end
            endcase
            load_geometry();
            if (phase == 3) rx_long_hold = 1'b1;
            if (phase == N_PHASES - 1) calm = 1'b1;
            repeat (N_RANDOM) begin
                if ($urandom_range(0, 1) != 0)
                    rand_forward();
                else
                    rand_inverse();
            end
        end

        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
